// File: design/tcrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the three-term recurrence checksum.
// No dependencies; used by tcrc_fold, tcrc_term and the top level.
package tcrc_pkg;

  // Recurrence state that travels between the top level and the step logic.
  typedef struct packed {
    logic        in_msg;
    logic [7:0]  pos;
    logic [15:0] older;
    logic [15:0] newer;
  } state_t;

  localparam logic [15:0] FIRST_OFFSET = 16'd7;
  localparam logic [7:0]  ALPHA_STEP   = 8'd17;
  localparam logic [7:0]  BETA_STEP    = 8'd31;
  localparam logic [16:0] MODULUS      = 17'd65535;

  // 256 * 65535 + 1: lifts a negative difference into range while adding
  // the extra one that the 64-bit wrap contributes (2^64 mod 65535 = 1).
  localparam logic [24:0] WRAP_BIAS = 25'd16776961;

  localparam state_t STATE_RESET = '{
    in_msg: 1'b0,
    pos:    8'd0,
    older:  16'd1,
    newer:  16'd0
  };

endpackage

// File: design/tcrc_fold.sv
`timescale 1ns / 1ps
// Reduction of a 25-bit value modulo 65535 by end-around folding.
// Uses tcrc_pkg for the modulus.
module tcrc_fold (
  input  logic [24:0] value,
  output logic [15:0] residue
);

  logic [16:0] folded;

  // 2^16 is one modulo 65535, so the high bits add onto the low half.
  assign folded  = 17'(value[24:16]) + 17'(value[15:0]);
  assign residue = (folded >= tcrc_pkg::MODULUS) ? 16'(folded - tcrc_pkg::MODULUS)
                                                  : folded[15:0];

endmodule

// File: design/tcrc_term.sv
`timescale 1ns / 1ps
// Next-state logic for one byte: first-byte seeding or one recurrence step.
// Uses tcrc_pkg for the state type and constants, and tcrc_fold.
module tcrc_term (
  input  tcrc_pkg::state_t cur,
  input  logic [7:0]       data_byte,
  output tcrc_pkg::state_t nxt
);

  logic [7:0]  alpha;
  logic [7:0]  beta;
  logic [8:0]  coef_a;
  logic [24:0] prod_a;
  logic [23:0] prod_b;
  logic        negative;
  logic [24:0] lifted;
  logic [15:0] new_term;

  // Position coefficients, reduced modulo 256 by truncation.
  assign alpha  = 8'(cur.pos * tcrc_pkg::ALPHA_STEP);
  assign beta   = 8'(cur.pos * tcrc_pkg::BETA_STEP);
  assign coef_a = 9'(data_byte) + 9'(alpha);

  assign prod_a = 25'(coef_a) * 25'(cur.newer);
  assign prod_b = 24'(beta) * 24'(cur.older);

  assign negative = prod_a < 25'(prod_b);
  assign lifted   = prod_a - 25'(prod_b) + (negative ? tcrc_pkg::WRAP_BIAS : 25'd0);

  tcrc_fold u_fold (
    .value   (lifted),
    .residue (new_term)
  );

  always_comb begin
    if (!cur.in_msg) begin
      nxt.in_msg = 1'b1;
      nxt.pos    = 8'd1;
      nxt.older  = 16'd1;
      nxt.newer  = 16'(data_byte) + tcrc_pkg::FIRST_OFFSET;
    end else begin
      nxt.in_msg = 1'b1;
      nxt.pos    = cur.pos + 8'd1;
      nxt.older  = cur.newer;
      nxt.newer  = new_term;
    end
  end

endmodule

// File: design/three_term_recurrence_checksum.sv
`timescale 1ns / 1ps
// Top level of the three-term recurrence checksum: input register, recurrence
// state, output register. Uses tcrc_pkg and tcrc_term.

// The block takes one message byte per beat, with final_byte set on the last
// byte, and delivers one 16-bit checksum beat per message. It sustains one
// byte per clock cycle unless a final byte meets a full output register: the
// recurrence step (two narrow multiplies, a subtract and a fold modulo 65535)
// is combinational from the state registers back to themselves, and that loop
// sets the rate. A byte is captured in the input register and applied to the
// state from there; a final byte, when applied, also loads the output
// register. The input side keeps taking bytes while a finished checksum
// waits; only a final byte that finds the output register still full holds
// the input register until the waiting checksum is taken. After a final byte
// the state returns to its reset values, ready for the next message.
module three_term_recurrence_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum
);

  // Input register.
  logic       in_full;
  logic [7:0] in_data;
  logic       in_final;

  // Recurrence state and its next value from the step logic.
  tcrc_pkg::state_t state;
  tcrc_pkg::state_t state_next;

  // Output register.
  logic [15:0] result;

  logic out_free;
  logic step_fire;

  // A non-final byte never needs the output register; a final one does.
  assign out_free  = !out_valid || out_ready;
  assign step_fire = in_full && (!in_final || out_free);
  assign in_ready  = !in_full || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data  <= data_byte;
      in_final <= final_byte;
    end
  end

  tcrc_term u_term (
    .cur       (state),
    .data_byte (in_data),
    .nxt       (state_next)
  );

  // The final byte of a message clears the state for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcrc_pkg::STATE_RESET;
    end else if (step_fire) begin
      state <= in_final ? tcrc_pkg::STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire && in_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && in_final) begin
      result <= state_next.newer;
    end
  end

  assign checksum = result;

`ifndef SYNTH
  // A final byte that is applied always leaves a checksum waiting.
  a_final_loads_out : assert property (@(posedge clk) disable iff (rst)
    step_fire && in_final |=> out_valid)
    else $error("final byte applied without a checksum");

  // A final byte returns the state to awaiting the first byte.
  a_final_clears : assert property (@(posedge clk) disable iff (rst)
    step_fire && in_final |=> !state.in_msg && state.pos == 8'd0)
    else $error("state not cleared after final byte");

  // A non-final byte leaves a message open.
  a_open_message : assert property (@(posedge clk) disable iff (rst)
    step_fire && !in_final |=> state.in_msg)
    else $error("message not open after non-final byte");

  // Terms are residues modulo 65535 and never reach 65535.
  a_term_range : assert property (@(posedge clk) disable iff (rst)
    state.in_msg |-> state.newer != 16'hFFFF && state.older != 16'hFFFF)
    else $error("recurrence term out of range");

  // A waiting checksum is never overwritten before it is taken.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(step_fire && in_final))
    else $error("checksum overwritten while waiting");
`endif

endmodule
